/* hdl/pcstm_pkg.sv */
// Package for the phase-continuous square tone mixer.
// Holds widths, constants, datapath op codes and control/status structs.
// No dependencies.
package pcstm_pkg;

    localparam int PHASE_BITS = 32;
    localparam int FREQ_W     = 16;
    localparam int DUR_W      = 16;
    localparam int SMP_W      = 16;
    localparam int SR_W       = 17;
    localparam int SL_W       = 23;
    localparam int DW         = PHASE_BITS + FREQ_W;
    localparam int DCNT_W     = $clog2(DW + 1);
    localparam int CNT_BITS   = DUR_W + SR_W;
    localparam int FRAC_BITS  = SR_W + FREQ_W + 1;
    localparam int PRD_W      = PHASE_BITS + SR_W;

    localparam logic [SMP_W-1:0] AMP_POS   = 16'h2000;
    localparam logic [SMP_W-1:0] AMP_NEG   = 16'hE000;
    localparam logic [SR_W-1:0]  MS_PER_S  = 17'd1000;
    localparam logic [SR_W-1:0]  SR_RESET  = 17'd44100;
    localparam logic [SL_W-1:0]  SL_MAX    = {SL_W{1'b1}};

    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_ENABLE      = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_PH,
        OP_MUL_DUR,
        OP_MUL_REM,
        OP_DIV_START,
        OP_WB_PHASE,
        OP_SET_TONE,
        OP_WB_COUNT,
        OP_WB_MIX,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        DS_PHASE,
        DS_COUNT,
        DS_MOD,
        DS_FRAC
    } t_dsel;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
        logic  idle;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic kind;
        logic freq_zero;
        logic no_mix;
        logic tone_zero;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

/* hdl/phase_continuous_square_tone_mixer_unit.sv */
// Top level of the phase-continuous square tone mixer: registers, datapath,
// output register. Uses pcstm_pkg, pcstm_seq and pcstm_div.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------------------
//  input   | i_in_valid | o_in_ready  | i_kind, i_tone_freq, i_tone_duration_ms,
//          |            |             | i_left_in, i_right_in
//  output  | o_out_valid| i_out_ready | o_is_sample, o_left_out, o_right_out,
//          |            |             | o_needs_tone, o_underrun
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// A tone rescales the phase unless its frequency is zero; a sample is passed through,
// mixed with silence, or mixed with the tone. The shared divider retires one quotient
// bit per cycle. Reset is synchronous; no clearing pass.
// A finished result waits in the output register while the next transfer is taken in;
// the sequencer holds its output step only while a second result is ready and the register is still full.
module phase_continuous_square_tone_mixer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [pcstm_pkg::FREQ_W-1:0]        i_tone_freq,
    input  logic [pcstm_pkg::DUR_W-1:0]         i_tone_duration_ms,
    input  logic signed [pcstm_pkg::SMP_W-1:0]  i_left_in,
    input  logic signed [pcstm_pkg::SMP_W-1:0]  i_right_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_is_sample,
    output logic signed [pcstm_pkg::SMP_W-1:0]  o_left_out,
    output logic signed [pcstm_pkg::SMP_W-1:0]  o_right_out,
    output logic                                o_needs_tone,
    output logic                                o_underrun,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [pcstm_pkg::SR_W-1:0]          i_cfg_data
);
    import pcstm_pkg::*;

    logic [SR_W-1:0]       r_sample_rate;
    logic                  r_enable;
    logic [SL_W-1:0]       r_samples_left;
    logic [FREQ_W-1:0]     r_tone_hz;
    logic [PHASE_BITS-1:0] r_phase;

    logic                  r_kind;
    logic [FREQ_W-1:0]     r_freq;
    logic [DUR_W-1:0]      r_dur;
    logic [SMP_W-1:0]      r_left;
    logic [SMP_W-1:0]      r_right;
    logic                  r_under;
    logic [DW-1:0]         r_acc;

    logic                  r_out_valid;
    logic                  r_o_is_sample;
    logic [SMP_W-1:0]      r_o_left;
    logic [SMP_W-1:0]      r_o_right;
    logic                  r_o_needs;
    logic                  r_o_under;

    t_ctrl                 w_ctrl;
    t_stat                 w_stat;
    logic                  w_accept;
    logic                  w_out_free;
    logic [SR_W-1:0]       w_sr1;
    logic [PHASE_BITS-1:0] w_mul_a;
    logic [SR_W-1:0]       w_mul_b;
    logic [PRD_W-1:0]      w_prod;
    logic                  w_div_start;
    logic [DW-1:0]         w_div_dividend;
    logic [DCNT_W-1:0]     w_div_len;
    logic [SR_W-1:0]       w_div_divisor;
    logic                  w_div_busy;
    logic [DW-1:0]         w_quo;
    logic [SR_W-1:0]       w_rem;
    logic [SMP_W-1:0]      w_tone_val;

    assign w_accept    = i_in_valid & o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_sr1       = (r_sample_rate == '0) ? SR_W'(1) : r_sample_rate;
    assign o_in_ready  = w_ctrl.idle;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_stat.accept    = w_accept;
        w_stat.kind      = r_kind;
        w_stat.freq_zero = (r_freq == '0);
        w_stat.no_mix    = !r_enable || (r_samples_left == '0);
        w_stat.tone_zero = (r_tone_hz == '0);
        w_stat.div_busy  = w_div_busy;
        w_stat.out_free  = w_out_free;
    end

    pcstm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // shared multiplier operand select
    always_comb begin
        case (w_ctrl.op)
            OP_MUL_PH: begin
                w_mul_a = r_phase;
                w_mul_b = SR_W'(r_tone_hz);
            end
            OP_MUL_DUR: begin
                w_mul_a = PHASE_BITS'(r_dur);
                w_mul_b = r_sample_rate;
            end
            default: begin
                w_mul_a = PHASE_BITS'(w_rem);
                w_mul_b = SR_W'(r_tone_hz);
            end
        endcase
    end

    assign w_prod = PRD_W'(w_mul_a) * PRD_W'(w_mul_b);

    // dividend is left aligned for the divider
    always_comb begin
        w_div_start = (w_ctrl.op == OP_DIV_START);
        case (w_ctrl.dsel)
            DS_PHASE: begin
                w_div_dividend = r_acc;
                w_div_len      = DCNT_W'(DW);
                w_div_divisor  = SR_W'(r_freq);
            end
            DS_COUNT: begin
                w_div_dividend = r_acc << (DW - CNT_BITS);
                w_div_len      = DCNT_W'(CNT_BITS);
                w_div_divisor  = MS_PER_S;
            end
            DS_MOD: begin
                w_div_dividend = {r_phase, {(DW - PHASE_BITS){1'b0}}};
                w_div_len      = DCNT_W'(PHASE_BITS);
                w_div_divisor  = w_sr1;
            end
            DS_FRAC: begin
                w_div_dividend = r_acc << (DW - FRAC_BITS);
                w_div_len      = DCNT_W'(FRAC_BITS);
                w_div_divisor  = w_sr1;
            end
            default: begin
                w_div_dividend = r_acc;
                w_div_len      = DCNT_W'(DW);
                w_div_divisor  = w_sr1;
            end
        endcase
    end

    pcstm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_len      (w_div_len),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    always_comb begin
        if (r_tone_hz == '0) begin
            w_tone_val = '0;
        end else if (w_quo[0]) begin
            w_tone_val = AMP_NEG;
        end else begin
            w_tone_val = AMP_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate  <= SR_RESET;
            r_enable       <= 1'b0;
            r_samples_left <= '0;
            r_tone_hz      <= '0;
            r_phase        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                    CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                    default:         r_enable      <= r_enable;
                endcase
            end

            if (w_accept) begin
                r_kind  <= i_kind;
                r_freq  <= i_tone_freq;
                r_dur   <= i_tone_duration_ms;
                r_left  <= i_left_in;
                r_right <= i_right_in;
                r_under <= i_kind & r_enable & (r_samples_left == '0);
            end

            if (w_ctrl.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_ctrl.op)
                OP_MUL_PH, OP_MUL_DUR: r_acc <= w_prod[DW-1:0];
                OP_MUL_REM:            r_acc <= {w_prod[DW-2:0], 1'b0};
                OP_WB_PHASE:           r_phase <= w_quo[PHASE_BITS-1:0];
                OP_SET_TONE:           r_tone_hz <= r_freq;
                OP_WB_COUNT: begin
                    if (w_quo[DW-1:SL_W] != '0) begin
                        r_samples_left <= SL_MAX;
                    end else begin
                        r_samples_left <= w_quo[SL_W-1:0];
                    end
                end
                OP_WB_MIX: begin
                    r_samples_left <= r_samples_left - 1'b1;
                    r_left         <= r_left + w_tone_val;
                    r_right        <= r_right + w_tone_val;
                    if (r_tone_hz != '0) begin
                        r_phase <= r_phase + 1'b1;
                    end
                end
                OP_OUT: begin
                    r_o_is_sample <= r_kind;
                    r_o_left      <= r_kind ? r_left : '0;
                    r_o_right     <= r_kind ? r_right : '0;
                    r_o_needs     <= (r_samples_left == '0);
                    r_o_under     <= r_under;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_sample  = r_o_is_sample;
    assign o_left_out   = r_o_left;
    assign o_right_out  = r_o_right;
    assign o_needs_tone = r_o_needs;
    assign o_underrun   = r_o_under;

`ifndef NO_ASSERTIONS
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_busy)
        else $error("input ready while divider busy");

    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after input transfer");

    a_underrun_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_underrun) |-> (o_is_sample && o_needs_tone))
        else $error("underrun on non-sample or with tone remaining");

    a_tone_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_sample) |-> (o_left_out == '0 && o_right_out == '0))
        else $error("tone result carries sample data");

    a_mix_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_WB_MIX) |-> (r_samples_left != '0 && r_enable))
        else $error("mix step with no samples left or disabled");
`endif

endmodule

/* hdl/pcstm_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Dividend arrives left aligned with its bit length; uses pcstm_pkg.
module pcstm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcstm_pkg::DW-1:0]      i_dividend,
    input  logic [pcstm_pkg::DCNT_W-1:0]  i_len,
    input  logic [pcstm_pkg::SR_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [pcstm_pkg::DW-1:0]      o_quo,
    output logic [pcstm_pkg::SR_W-1:0]    o_rem
);
    import pcstm_pkg::*;

    logic [DW-1:0]     r_dq;
    logic [SR_W-1:0]   r_dr;
    logic [SR_W-1:0]   r_dd;
    logic [DCNT_W-1:0] r_cnt;
    logic [SR_W:0]     w_trial;
    logic              w_fit;

    assign w_trial = {r_dr, r_dq[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dd});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_len;
            r_dq  <= i_dividend;
            r_dr  <= '0;
            r_dd  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_dq  <= {r_dq[DW-2:0], w_fit};
            if (w_fit) begin
                r_dr <= SR_W'(w_trial - {1'b0, r_dd});
            end else begin
                r_dr <= w_trial[SR_W-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_dq;
    assign o_rem  = r_dr;

endmodule

/* hdl/pcstm_seq.sv */
// Microcode sequencer: step counter plus read-only control store.
// Drives the mixer datapath through t_ctrl; uses pcstm_pkg.
module pcstm_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcstm_pkg::t_stat i_stat,
    output pcstm_pkg::t_ctrl o_ctrl
);
    import pcstm_pkg::*;

    localparam int PC_W = 5;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_KIND,
        C_FREQ_ZERO,
        C_NO_MIX,
        C_TONE_ZERO
    } t_cond;

    typedef enum logic [1:0] {
        H_NONE,
        H_ACCEPT,
        H_DIV,
        H_OUT
    } t_hold;

    typedef struct packed {
        t_op             op;
        t_dsel           dsel;
        t_hold           hold;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ucode;

    localparam logic [PC_W-1:0] S_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] S_DISPATCH = 5'd1;
    localparam logic [PC_W-1:0] S_T_CHECK  = 5'd2;
    localparam logic [PC_W-1:0] S_T_MUL    = 5'd3;
    localparam logic [PC_W-1:0] S_T_DIV    = 5'd4;
    localparam logic [PC_W-1:0] S_T_DWAIT  = 5'd5;
    localparam logic [PC_W-1:0] S_T_WBPH   = 5'd6;
    localparam logic [PC_W-1:0] S_T_TONE   = 5'd7;
    localparam logic [PC_W-1:0] S_C_MUL    = 5'd8;
    localparam logic [PC_W-1:0] S_C_DIV    = 5'd9;
    localparam logic [PC_W-1:0] S_C_DWAIT  = 5'd10;
    localparam logic [PC_W-1:0] S_C_WB     = 5'd11;
    localparam logic [PC_W-1:0] S_S_CHECK  = 5'd13;
    localparam logic [PC_W-1:0] S_S_TONE   = 5'd14;
    localparam logic [PC_W-1:0] S_M_DIV    = 5'd15;
    localparam logic [PC_W-1:0] S_M_DWAIT  = 5'd16;
    localparam logic [PC_W-1:0] S_F_MUL    = 5'd17;
    localparam logic [PC_W-1:0] S_F_DIV    = 5'd18;
    localparam logic [PC_W-1:0] S_F_DWAIT  = 5'd19;
    localparam logic [PC_W-1:0] S_MIX      = 5'd20;
    localparam logic [PC_W-1:0] S_OUT      = 5'd21;

    function automatic t_ucode f_ucode(input logic [PC_W-1:0] pc);
        t_ucode u;
        u = '{op: OP_NOP, dsel: DS_PHASE, hold: H_NONE, cond: C_NONE, target: S_IDLE};
        case (pc)
            S_IDLE:     u.hold = H_ACCEPT;
            S_DISPATCH: begin
                u.cond   = C_KIND;
                u.target = S_S_CHECK;
            end
            S_T_CHECK:  begin
                u.cond   = C_FREQ_ZERO;
                u.target = S_T_TONE;
            end
            S_T_MUL:    u.op = OP_MUL_PH;
            S_T_DIV:    begin
                u.op   = OP_DIV_START;
                u.dsel = DS_PHASE;
            end
            S_T_DWAIT:  u.hold = H_DIV;
            S_T_WBPH:   u.op = OP_WB_PHASE;
            S_T_TONE:   u.op = OP_SET_TONE;
            S_C_MUL:    u.op = OP_MUL_DUR;
            S_C_DIV:    begin
                u.op   = OP_DIV_START;
                u.dsel = DS_COUNT;
            end
            S_C_DWAIT:  u.hold = H_DIV;
            S_C_WB:     begin
                u.op     = OP_WB_COUNT;
                u.cond   = C_ALWAYS;
                u.target = S_OUT;
            end
            S_S_CHECK:  begin
                u.cond   = C_NO_MIX;
                u.target = S_OUT;
            end
            S_S_TONE:   begin
                u.cond   = C_TONE_ZERO;
                u.target = S_MIX;
            end
            S_M_DIV:    begin
                u.op   = OP_DIV_START;
                u.dsel = DS_MOD;
            end
            S_M_DWAIT:  u.hold = H_DIV;
            S_F_MUL:    u.op = OP_MUL_REM;
            S_F_DIV:    begin
                u.op   = OP_DIV_START;
                u.dsel = DS_FRAC;
            end
            S_F_DWAIT:  u.hold = H_DIV;
            S_MIX:      u.op = OP_WB_MIX;
            S_OUT:      begin
                u.op     = OP_OUT;
                u.hold   = H_OUT;
                u.cond   = C_ALWAYS;
                u.target = S_IDLE;
            end
            default:    u.cond = C_ALWAYS;
        endcase
        return u;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ucode          w_uc;
    logic            w_hold;
    logic            w_take;

    always_comb begin
        w_uc = f_ucode(r_pc);
        case (w_uc.hold)
            H_NONE:   w_hold = 1'b0;
            H_ACCEPT: w_hold = !i_stat.accept;
            H_DIV:    w_hold = i_stat.div_busy;
            H_OUT:    w_hold = !i_stat.out_free;
            default:  w_hold = 1'b0;
        endcase
        case (w_uc.cond)
            C_NONE:      w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_KIND:      w_take = i_stat.kind;
            C_FREQ_ZERO: w_take = i_stat.freq_zero;
            C_NO_MIX:    w_take = i_stat.no_mix;
            C_TONE_ZERO: w_take = i_stat.tone_zero;
            default:     w_take = 1'b0;
        endcase
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uc.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
        o_ctrl.op   = w_hold ? OP_NOP : w_uc.op;
        o_ctrl.dsel = w_uc.dsel;
        o_ctrl.idle = (r_pc == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* test/pcstm_result_checker.sv */
// Result checker for the phase-continuous square tone mixer: watches the input,
// output and config channels, predicts each result and compares it field by field.
// Depends on pcstm_pkg.
module pcstm_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_kind,
    input  logic [pcstm_pkg::FREQ_W-1:0]        i_tone_freq,
    input  logic [pcstm_pkg::DUR_W-1:0]         i_tone_duration_ms,
    input  logic signed [pcstm_pkg::SMP_W-1:0]  i_left_in,
    input  logic signed [pcstm_pkg::SMP_W-1:0]  i_right_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_is_sample,
    input  logic signed [pcstm_pkg::SMP_W-1:0]  i_left_out,
    input  logic signed [pcstm_pkg::SMP_W-1:0]  i_right_out,
    input  logic                                i_needs_tone,
    input  logic                                i_underrun,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [pcstm_pkg::SR_W-1:0]          i_cfg_data,
    output int                                  o_mismatch_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pcstm_pkg::*;

    typedef struct packed {
        logic             is_sample;
        logic [SMP_W-1:0] left;
        logic [SMP_W-1:0] right;
        logic             needs_tone;
        logic             underrun;
    } t_mix_result;

    logic [SR_W-1:0]       rate_q;
    logic                  enable_q;
    logic [SL_W-1:0]       samples_q;
    logic [FREQ_W-1:0]     tone_hz_q;
    logic [PHASE_BITS-1:0] phase_q;
    t_mix_result           mix_expected[$];
    int                    mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    function automatic t_mix_result mix_predict(input logic kind,
                                                input logic [FREQ_W-1:0] freq,
                                                input logic [DUR_W-1:0] dur,
                                                input logic [SMP_W-1:0] left,
                                                input logic [SMP_W-1:0] right);
        logic [63:0]      wide;
        logic [63:0]      rate;
        logic [63:0]      rem;
        logic [SMP_W-1:0] tone_val;
        t_mix_result      r;
        r = '0;
        if (!kind) begin
            // rescale the phase so the square wave stays continuous
            if (freq != '0) begin
                wide = (64'(phase_q) * 64'(tone_hz_q)) / 64'(freq);
                phase_q = wide[PHASE_BITS-1:0];
            end
            tone_hz_q = freq;
            wide = (64'(dur) * 64'(rate_q)) / 64'(MS_PER_S);
            samples_q = (wide > 64'(SL_MAX)) ? SL_MAX : wide[SL_W-1:0];
        end else begin
            r.is_sample = 1'b1;
            r.left      = left;
            r.right     = right;
            if (enable_q) begin
                if (samples_q == '0) begin
                    r.underrun = 1'b1;
                end else begin
                    tone_val = '0;
                    if (tone_hz_q != '0) begin
                        rate = (rate_q == '0) ? 64'd1 : 64'(rate_q);
                        rem  = 64'(phase_q) % rate;
                        wide = (rem * 64'd2 * 64'(tone_hz_q)) / rate;
                        tone_val = wide[0] ? AMP_NEG : AMP_POS;
                        phase_q = phase_q + 1'b1;
                    end
                    samples_q = samples_q - 1'b1;
                    r.left    = left + tone_val;
                    r.right   = right + tone_val;
                end
            end
        end
        r.needs_tone = (samples_q == '0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_mix_result want;
        if (!i_rst_n) begin
            rate_q    = SR_RESET;
            enable_q  = 1'b0;
            samples_q = '0;
            tone_hz_q = '0;
            phase_q   = '0;
            mix_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (mix_expected.size() == 0) begin
                    report_mismatch("result transfer with nothing expected",
                                    {i_left_out, i_right_out}, '0);
                end else begin
                    want = mix_expected.pop_front();
                    if (i_is_sample !== want.is_sample)
                        report_mismatch("is_sample", 32'(i_is_sample),
                                        32'(want.is_sample));
                    if (i_left_out !== want.left)
                        report_mismatch("left_out", 32'($unsigned(i_left_out)),
                                        32'(want.left));
                    if (i_right_out !== want.right)
                        report_mismatch("right_out", 32'($unsigned(i_right_out)),
                                        32'(want.right));
                    if (i_needs_tone !== want.needs_tone)
                        report_mismatch("needs_tone", 32'(i_needs_tone),
                                        32'(want.needs_tone));
                    if (i_underrun !== want.underrun)
                        report_mismatch("underrun", 32'(i_underrun),
                                        32'(want.underrun));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SAMPLE_RATE)
                    rate_q = i_cfg_data;
                else
                    enable_q = i_cfg_data[0];
            end
            if (i_in_valid && i_in_ready)
                mix_expected.push_back(mix_predict(i_kind, i_tone_freq, i_tone_duration_ms,
                                                   i_left_in, i_right_in));
        end
        o_pending <= mix_expected.size();
    end

endmodule

/* test/phase_continuous_square_tone_mixer_unit_tb.sv */
// Testbench top for the phase-continuous square tone mixer: clock, reset,
// directed and random tone/sample stimulus, config writes, output stalls, verdict.
// Depends on pcstm_pkg, pcstm_result_checker and the mixer RTL.
module phase_continuous_square_tone_mixer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcstm_pkg::*;

    localparam int ITEM_TARGET  = 2000;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 120;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    kind       = 1'b0;
    logic [FREQ_W-1:0]       tone_freq  = '0;
    logic [DUR_W-1:0]        tone_dur   = '0;
    logic signed [SMP_W-1:0] left_in    = '0;
    logic signed [SMP_W-1:0] right_in   = '0;
    logic                    out_ready  = 1'b0;
    logic                    cfg_valid  = 1'b0;
    logic                    cfg_index  = CFG_SAMPLE_RATE;
    logic [SR_W-1:0]         cfg_data   = '0;

    logic                    in_ready;
    logic                    out_valid;
    logic                    is_sample;
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
    logic                    needs_tone;
    logic                    underrun;
    logic                    cfg_ready;

    int                      mismatch_count;
    int                      pending;
    int                      items_sent  = 0;
    int                      quiet_cycles = 0;
    logic                    gaps_on     = 1'b1;
    logic                    hold_long   = 1'b0;
    logic [SR_W-1:0]         cur_rate    = SR_RESET;

    phase_continuous_square_tone_mixer_unit u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_kind             (kind),
        .i_tone_freq        (tone_freq),
        .i_tone_duration_ms (tone_dur),
        .i_left_in          (left_in),
        .i_right_in         (right_in),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_is_sample        (is_sample),
        .o_left_out         (left_out),
        .o_right_out        (right_out),
        .o_needs_tone       (needs_tone),
        .o_underrun         (underrun),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    pcstm_result_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_kind             (kind),
        .i_tone_freq        (tone_freq),
        .i_tone_duration_ms (tone_dur),
        .i_left_in          (left_in),
        .i_right_in         (right_in),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_is_sample        (is_sample),
        .i_left_out         (left_out),
        .i_right_out        (right_out),
        .i_needs_tone       (needs_tone),
        .i_underrun         (underrun),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_mismatch_count   (mismatch_count),
        .o_pending          (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic k, input logic [FREQ_W-1:0] f,
                             input logic [DUR_W-1:0] d, input logic [SMP_W-1:0] l,
                             input logic [SMP_W-1:0] r);
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        tone_freq <= f;
        tone_dur  <= d;
        left_in   <= l;
        right_in  <= r;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // drop valid and wait until every predicted result has been taken
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [SR_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SAMPLE_RATE)
            cur_rate = data;
    endtask

    function automatic logic [SR_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return 17'd1000;
            1:       return 17'd8000;
            2:       return 17'd44100;
            3:       return 17'd96000;
            4:       return '0;
            5:       return '1;
            6, 7:    return SR_W'($urandom_range(1000, 96000));
            8:       return SR_W'($urandom);
            default: return SR_W'($urandom_range(1, 999));
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return FREQ_W'($urandom_range(1, 10));
            3, 4:    return FREQ_W'($urandom);
            default: return FREQ_W'($urandom_range(20, 2000));
        endcase
    endfunction

    initial begin : receiver
        int stall;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 11) : 0;
                if (stall != 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        longint unsigned tone_len;
        int              n;
        int              phase_no;
        int              phase_end;
        logic [DUR_W-1:0] d;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: disabled pass-through, loads while disabled, wraps, underrun,
        // silence, zero duration, saturated count, zero sample rate
        write_reg(CFG_SAMPLE_RATE, 17'd1000);
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
        send_item(1'b0, 16'hFFFF, 16'd3, 16'h1234, 16'hFEDC);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
        settle();
        write_reg(CFG_ENABLE, 17'd1);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        send_item(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(1'b0, 16'd1, 16'd2, 16'h0000, 16'h0000);
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'h6000, 16'hA000);
        send_item(1'b1, 16'h0000, 16'h0000, 16'hE000, 16'h1FFF);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h4321, 16'h8765);
        send_item(1'b0, 16'd0, 16'd2, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        send_item(1'b0, 16'd0, 16'd0, 16'h0000, 16'h0000);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0100, 16'hFF00);
        send_item(1'b0, 16'd12345, 16'hFFFF, 16'h0000, 16'h0000);
        settle();
        write_reg(CFG_SAMPLE_RATE, '1);
        send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
        settle();
        write_reg(CFG_SAMPLE_RATE, '0);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h1111, 16'h2222);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h3333, 16'h4444);
        send_item(1'b0, 16'd300, 16'd5, 16'h0000, 16'h0000);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h5555, 16'h6666);

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            write_reg(CFG_SAMPLE_RATE, pick_rate());
            write_reg(CFG_ENABLE, SR_W'($urandom_range(0, 4) != 0));
            gaps_on = ($urandom_range(0, 2) != 0);
            if (phase_no == 2) begin
                gaps_on   = 1'b0;
                hold_long = 1'b1;
            end
            phase_end = items_sent + $urandom_range(40, 160);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 15) begin
                    repeat ($urandom_range(1, 4)) send_noise();
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        d = DUR_W'($urandom);
                    else if (cur_rate <= 17'd2000)
                        d = DUR_W'($urandom_range(0, 40));
                    else
                        d = DUR_W'($urandom_range(0, 3));
                    send_item(1'b0, pick_freq(), d, 16'($urandom), 16'($urandom));
                    tone_len = (longint'(d) * longint'(cur_rate)) / 1000;
                    n = (tone_len <= 30) ? int'(tone_len) + $urandom_range(0, 2)
                                         : $urandom_range(1, 30);
                    repeat (n)
                        send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                end
            end
            phase_no++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* phase_continuous_square_tone_mixer_unit.f */
hdl/pcstm_pkg.sv
hdl/pcstm_div.sv
hdl/pcstm_seq.sv
hdl/phase_continuous_square_tone_mixer_unit.sv
test/pcstm_result_checker.sv
test/phase_continuous_square_tone_mixer_unit_tb.sv
